[rtl/mbei_pkg.sv]
// ----------------------------------------------------------------------------
// Mandelbrot escape iteration package
// Widths and types shared by the front and back, and the component clamp used by the back.
// ----------------------------------------------------------------------------
package mbei_pkg;

	localparam int CFB = 60;
	localparam int IW = 24;
	localparam int MAG_SHIFT = 2 * CFB - 26;

	typedef logic signed [63:0] coord_t;
	typedef logic signed [127:0] wide_t;
	typedef logic [IW-1:0] iter_t;

	typedef struct packed {
		coord_t cr;
		coord_t ci;
		logic   interior;
	} job_t;

	function automatic coord_t clamp_comp(input wide_t v);
		wide_t lim;
		lim = wide_t'(1) <<< (CFB + 3);
		if (v >= lim) begin
			return coord_t'(lim - wide_t'(1));
		end
		if (v < -lim) begin
			return coord_t'(-lim);
		end
		return v[63:0];
	endfunction

endpackage

[rtl/mbei_mul.sv]
// ----------------------------------------------------------------------------
// Sequential signed multiplier
// Forms a 64 x 64 signed product from four registered 32 x 32 partial products.
// ----------------------------------------------------------------------------
module mbei_mul (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  mbei_pkg::coord_t a,
	input  mbei_pkg::coord_t b,
	output logic            done,
	output mbei_pkg::wide_t prod
);
	import mbei_pkg::*;

	logic [63:0]  ma_q, mb_q;
	logic         neg_q;
	logic [2:0]   cnt_q;
	logic         busy_q, done_q;
	logic [63:0]  pp_s1;
	logic [6:0]   sh_s1;
	logic [127:0] acc_q;
	wide_t        prod_q;
	logic [31:0]  opx, opy;
	logic [6:0]   sh;

	always_comb begin
		case (cnt_q[1:0])
			2'd0: begin opx = ma_q[31:0];  opy = mb_q[31:0];  sh = 7'd0;  end
			2'd1: begin opx = ma_q[31:0];  opy = mb_q[63:32]; sh = 7'd32; end
			2'd2: begin opx = ma_q[63:32]; opy = mb_q[31:0];  sh = 7'd32; end
			default: begin opx = ma_q[63:32]; opy = mb_q[63:32]; sh = 7'd64; end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 3'd1;
				if (cnt_q == 3'd5) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			ma_q  <= a[63] ? 64'(-a) : a;
			mb_q  <= b[63] ? 64'(-b) : b;
			neg_q <= a[63] ^ b[63];
			acc_q <= '0;
		end else if (busy_q) begin
			if (cnt_q < 3'd4) begin
				pp_s1 <= 64'(opx * opy);
				sh_s1 <= sh;
			end
			if (cnt_q >= 3'd1 && cnt_q <= 3'd4) begin
				acc_q <= acc_q + ({64'd0, pp_s1} << sh_s1);
			end
			if (cnt_q == 3'd5) begin
				prod_q <= neg_q ? -$signed(acc_q) : $signed(acc_q);
			end
		end
	end

	assign done = done_q;
	assign prod = prod_q;
endmodule

[rtl/mbei_queue.sv]
// ----------------------------------------------------------------------------
// Job queue
// Two-entry queue that carries classified points from the front to the back.
// ----------------------------------------------------------------------------
module mbei_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  mbei_pkg::job_t wr_data,
	input  logic           pop,
	output logic           full,
	output logic           not_empty,
	output mbei_pkg::job_t rd_data
);
	import mbei_pkg::*;

	job_t       mem_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	assign full      = (cnt_q == 2'd2);
	assign not_empty = (cnt_q != 2'd0);
	assign rd_data   = mem_q[rd_ptr_q];
endmodule

[rtl/mbei_front.sv]
// ----------------------------------------------------------------------------
// Point classifier
// Accepts points and tests them against the main cardioid and period-2 bulb.
// ----------------------------------------------------------------------------
module mbei_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  mbei_pkg::coord_t point_real,
	input  mbei_pkg::coord_t point_imag,
	input  logic             q_full,
	output logic             q_push,
	output mbei_pkg::job_t   q_data
);
	import mbei_pkg::*;

	typedef enum logic [5:0] {
		F_IDLE = 6'b000001,
		F_CY2  = 6'b000010,
		F_XS2  = 6'b000100,
		F_CARD = 6'b001000,
		F_BULB = 6'b010000,
		F_PUSH = 6'b100000
	} fstate_t;

	localparam coord_t ONE = coord_t'(1) <<< CFB;
	localparam coord_t QUARTER = coord_t'(1) <<< (CFB - 2);
	localparam wide_t BULB_R2 = wide_t'(1) <<< (2 * CFB - 4);

	fstate_t state_q;
	coord_t  cr_q, ci_q;
	wide_t   cy2_q;
	logic    interior_q;
	logic    accept, in_range;
	logic    mul_start, mul_done;
	coord_t  mul_a, mul_b, xs, qn, pp;
	wide_t   prod;

	assign accept = in_valid && !in_stall;
	assign in_stall = (state_q != F_IDLE);
	assign in_range = (point_real >= -(ONE <<< 1)) && (point_real < ONE)
		&& (point_imag >= -ONE) && (point_imag <= ONE);
	assign xs = cr_q - QUARTER;
	assign pp = cr_q + ONE;
	assign qn = coord_t'((prod + cy2_q) >>> CFB);

	always_comb begin
		mul_start = 1'b0;
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			F_IDLE: begin
				mul_start = accept && in_range;
				mul_a = point_imag;
				mul_b = point_imag;
			end
			F_CY2: begin
				mul_start = mul_done;
				mul_a = xs;
				mul_b = xs;
			end
			F_XS2: begin
				mul_start = mul_done;
				mul_a = qn;
				mul_b = qn + xs;
			end
			F_CARD: begin
				mul_start = mul_done && ((cy2_q >>> 2) < prod);
				mul_a = pp;
				mul_b = pp;
			end
			default: begin
				mul_start = 1'b0;
			end
		endcase
	end

	mbei_mul u_mul (
		.clk   (clk),
		.arst_n(arst_n),
		.start (mul_start),
		.a     (mul_a),
		.b     (mul_b),
		.done  (mul_done),
		.prod  (prod)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (accept) begin
						state_q <= in_range ? F_CY2 : F_PUSH;
					end
				end
				F_CY2: begin
					if (mul_done) begin
						state_q <= F_XS2;
					end
				end
				F_XS2: begin
					if (mul_done) begin
						state_q <= F_CARD;
					end
				end
				F_CARD: begin
					if (mul_done) begin
						state_q <= ((cy2_q >>> 2) < prod) ? F_BULB : F_PUSH;
					end
				end
				F_BULB: begin
					if (mul_done) begin
						state_q <= F_PUSH;
					end
				end
				F_PUSH: begin
					if (!q_full) begin
						state_q <= F_IDLE;
					end
				end
				default: begin
					state_q <= F_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cr_q <= point_real;
			ci_q <= point_imag;
			interior_q <= 1'b0;
		end
		if (state_q == F_CY2 && mul_done) begin
			cy2_q <= prod;
		end
		if (state_q == F_CARD && mul_done) begin
			interior_q <= !((cy2_q >>> 2) < prod);
		end
		if (state_q == F_BULB && mul_done) begin
			interior_q <= !(BULB_R2 < (prod + cy2_q));
		end
	end

	assign q_push = (state_q == F_PUSH) && !q_full;
	assign q_data = '{cr: cr_q, ci: ci_q, interior: interior_q};
endmodule

[rtl/mbei_back.sv]
// ----------------------------------------------------------------------------
// Escape iteration engine
// Iterates z = z^2 + c with periodicity detection and holds the result item.
// ----------------------------------------------------------------------------
module mbei_back (
	input  logic             clk,
	input  logic             arst_n,
	input  mbei_pkg::iter_t  budget,
	input  logic             q_not_empty,
	input  mbei_pkg::job_t   q_data,
	output logic             q_pop,
	output logic             out_valid,
	input  logic             out_stall,
	output mbei_pkg::iter_t  iterations,
	output logic [31:0]      final_magnitude_sq
);
	import mbei_pkg::*;

	typedef enum logic [6:0] {
		B_IDLE  = 7'b0000001,
		B_CHECK = 7'b0000010,
		B_MXY   = 7'b0000100,
		B_MXX   = 7'b0001000,
		B_MYY   = 7'b0010000,
		B_PER   = 7'b0100000,
		B_OUT   = 7'b1000000
	} bstate_t;

	localparam wide_t FOUR = wide_t'(1) <<< (2 * CFB + 2);

	bstate_t     state_q;
	coord_t      cr_q, ci_q, zx_q, zy_q, sx_q, sy_q;
	wide_t       zx2_q, zy2_q;
	iter_t       n_q;
	logic [IW:0] save_at_q;
	logic        res_int_q;
	logic        out_valid_q;
	iter_t       out_iter_q;
	logic [31:0] out_mag_q;

	logic        go_on, periodic, out_load, mul_start, mul_done;
	coord_t      mul_a, mul_b, nzx, nzy;
	wide_t       prod, mag_sum, mag;
	logic [63:0] ax, ay;
	logic [64:0] tol, dx, dy;

	assign mag_sum = zx2_q + zy2_q;
	assign go_on = (mag_sum < FOUR) && (n_q < budget);
	assign nzy = clamp_comp((prod >>> (CFB - 1)) + wide_t'(ci_q));
	assign nzx = clamp_comp(((zx2_q - zy2_q) >>> CFB) + wide_t'(cr_q));
	assign ax = zx_q[63] ? 64'(-zx_q) : zx_q;
	assign ay = zy_q[63] ? 64'(-zy_q) : zy_q;
	assign tol = (({1'b0, ax} + {1'b0, ay}) >> 50) + 65'd1;
	assign dx = (zx_q < sx_q) ? 65'($signed({sx_q[63], sx_q}) - $signed({zx_q[63], zx_q}))
		: 65'($signed({zx_q[63], zx_q}) - $signed({sx_q[63], sx_q}));
	assign dy = (zy_q < sy_q) ? 65'($signed({sy_q[63], sy_q}) - $signed({zy_q[63], zy_q}))
		: 65'($signed({zy_q[63], zy_q}) - $signed({sy_q[63], sy_q}));
	assign periodic = (dx < tol) && (dy < tol);
	assign mag = mag_sum >>> MAG_SHIFT;
	assign out_load = (state_q == B_OUT) && (!out_valid_q || !out_stall);
	assign q_pop = (state_q == B_IDLE) && q_not_empty;

	always_comb begin
		mul_start = 1'b0;
		mul_a = zx_q;
		mul_b = zy_q;
		case (state_q)
			B_CHECK: begin
				mul_start = go_on;
			end
			B_MXY: begin
				mul_start = mul_done;
				mul_a = nzx;
				mul_b = nzx;
			end
			B_MXX: begin
				mul_start = mul_done;
				mul_a = zy_q;
				mul_b = zy_q;
			end
			default: begin
				mul_start = 1'b0;
			end
		endcase
	end

	mbei_mul u_mul (
		.clk   (clk),
		.arst_n(arst_n),
		.start (mul_start),
		.a     (mul_a),
		.b     (mul_b),
		.done  (mul_done),
		.prod  (prod)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				B_IDLE: begin
					if (q_not_empty) begin
						state_q <= q_data.interior ? B_OUT : B_CHECK;
					end
				end
				B_CHECK: begin
					state_q <= go_on ? B_MXY : B_OUT;
				end
				B_MXY: begin
					if (mul_done) begin
						state_q <= B_MXX;
					end
				end
				B_MXX: begin
					if (mul_done) begin
						state_q <= B_MYY;
					end
				end
				B_MYY: begin
					if (mul_done) begin
						state_q <= B_PER;
					end
				end
				B_PER: begin
					state_q <= periodic ? B_OUT : B_CHECK;
				end
				B_OUT: begin
					if (out_load) begin
						state_q <= B_IDLE;
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE: begin
				cr_q      <= q_data.cr;
				ci_q      <= q_data.ci;
				res_int_q <= q_data.interior;
				zx_q      <= '0;
				zy_q      <= '0;
				sx_q      <= '0;
				sy_q      <= '0;
				zx2_q     <= '0;
				zy2_q     <= '0;
				n_q       <= '0;
				save_at_q <= (IW + 1)'(8);
			end
			B_MXY: begin
				if (mul_done) begin
					zx_q <= nzx;
					zy_q <= nzy;
					n_q  <= n_q + iter_t'(1);
				end
			end
			B_MXX: begin
				if (mul_done) begin
					zx2_q <= prod;
				end
			end
			B_MYY: begin
				if (mul_done) begin
					zy2_q <= prod;
				end
			end
			B_PER: begin
				if (periodic) begin
					res_int_q <= 1'b1;
				end else if ({1'b0, n_q} == save_at_q) begin
					sx_q      <= zx_q;
					sy_q      <= zy_q;
					save_at_q <= save_at_q << 1;
				end
			end
			default: begin
			end
		endcase
		if (out_load) begin
			out_iter_q <= res_int_q ? budget : n_q;
			if (res_int_q) begin
				out_mag_q <= '0;
			end else if (mag[127:32] != '0) begin
				out_mag_q <= 32'hFFFF_FFFF;
			end else begin
				out_mag_q <= mag[31:0];
			end
		end
	end

	assign out_valid = out_valid_q;
	assign iterations = out_iter_q;
	assign final_magnitude_sq = out_mag_q;
endmodule

[rtl/mandelbrot_escape_iteration.sv]
// Flow: a point outside the test range goes to the push state once it is accepted; one
// inside is decided by the cardioid test or else the bulb test, and is pushed when the queue has room.
// Each engine iteration runs the multiplier three times between its escape and periodicity checks.
// Throughput: one point at a time in the classifier and one in the engine.
// Reset: arst_n clears all control state and sets the budget to 1000.
// ----------------------------------------------------------------------------
// Mandelbrot escape iteration
// Top level: budget register, point classifier, job queue and iteration engine.
// ----------------------------------------------------------------------------
module mandelbrot_escape_iteration (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  mbei_pkg::iter_t  cfg_data,
	input  logic             in_valid,
	output logic             in_stall,
	input  mbei_pkg::coord_t point_real,
	input  mbei_pkg::coord_t point_imag,
	output logic             out_valid,
	input  logic             out_stall,
	output mbei_pkg::iter_t  iterations,
	output logic [31:0]      final_magnitude_sq
);
	import mbei_pkg::*;

	iter_t budget_q;
	logic  q_push, q_pop, q_full, q_not_empty;
	job_t  q_wr, q_rd;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			budget_q <= iter_t'(1000);
		end else if (cfg_valid && cfg_ready) begin
			budget_q <= cfg_data;
		end
	end

	mbei_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.point_real(point_real),
		.point_imag(point_imag),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_data    (q_wr)
	);

	mbei_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.wr_data  (q_wr),
		.pop      (q_pop),
		.full     (q_full),
		.not_empty(q_not_empty),
		.rd_data  (q_rd)
	);

	mbei_back u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.budget            (budget_q),
		.q_not_empty       (q_not_empty),
		.q_data            (q_rd),
		.q_pop             (q_pop),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.iterations        (iterations),
		.final_magnitude_sq(final_magnitude_sq)
	);

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_push && q_full))
		else $error("Queue written while full.");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_not_empty)
		else $error("Queue read while empty.");

	a_iter_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (iterations <= budget_q))
		else $error("Iteration count exceeds the budget.");
endmodule

[tb/mbei_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Mandelbrot escape iteration checker
// Watches the configuration, point and result channels of the block. It keeps
// its own copy of the iteration budget, works out the escape count and final
// squared magnitude of every accepted point, and compares each result item in
// order against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module mbei_checker (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  mbei_pkg::iter_t       cfg_data,
	input  logic                  in_valid,
	input  logic                  in_stall,
	input  mbei_pkg::coord_t      point_real,
	input  mbei_pkg::coord_t      point_imag,
	input  logic                  out_valid,
	input  logic                  out_stall,
	input  mbei_pkg::iter_t       iterations,
	input  logic [31:0]           final_magnitude_sq,
	output int                    fail_count,
	output int                    pending_count,
	output int                    checked_count,
	output int                    interior_count
);
	import mbei_pkg::*;

	typedef struct {
		iter_t       iters;
		logic [31:0] mag;
	} escape_t;

	escape_t expected_escapes[$];
	iter_t   budget;

	function automatic logic signed [63:0] sat_coord(input logic signed [127:0] v);
		logic signed [127:0] lim;
		lim = 128'sd1 <<< 63;
		if (v >= lim) begin
			return 64'h7FFF_FFFF_FFFF_FFFF;
		end
		if (v < -lim) begin
			return 64'h8000_0000_0000_0000;
		end
		return v[63:0];
	endfunction

	function automatic logic in_main_body(input logic signed [63:0] cr,
		input logic signed [63:0] ci);
		logic signed [127:0] x, y, one, cy2, prod, sq;
		logic signed [63:0] xs, q, qx, p;
		one = 128'sd1 <<< CFB;
		x = 128'(cr);
		y = 128'(ci);
		if (x < -(one <<< 1) || x >= one) begin
			return 1'b0;
		end
		if (y < -one || y > one) begin
			return 1'b0;
		end
		xs = cr - (64'sd1 <<< (CFB - 2));
		cy2 = y * y;
		sq = 128'(xs);
		sq = sq * sq + cy2;
		sq = sq >>> CFB;
		q = sq[63:0];
		qx = q + xs;
		prod = 128'(q);
		sq = 128'(qx);
		prod = prod * sq;
		if (!((cy2 >>> 2) < prod)) begin
			return 1'b1;
		end
		p = cr + (64'sd1 <<< CFB);
		sq = 128'(p);
		sq = sq * sq + cy2;
		if (!((128'sd1 <<< (2 * CFB - 4)) < sq)) begin
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic escape_t escape_result(input logic signed [63:0] cr,
		input logic signed [63:0] ci, input iter_t lim_iters);
		escape_t r;
		logic signed [63:0] zx, zy, sx, sy, nzx, nzy;
		logic signed [127:0] wx, wy, zx2, zy2, four, mag;
		logic [63:0] ax, ay, half, tol, dx, dy;
		logic [31:0] n, save_at;
		r.iters = lim_iters;
		r.mag = '0;
		if (in_main_body(cr, ci)) begin
			return r;
		end
		zx = 0; zy = 0; sx = 0; sy = 0; n = 0; save_at = 8;
		zx2 = 0; zy2 = 0;
		four = 128'sd1 <<< (2 * CFB + 2);
		while ((zx2 + zy2) < four && n < 32'(lim_iters)) begin
			wx = 128'(zx);
			wy = 128'(zy);
			nzy = sat_coord(((wx * wy) >>> (CFB - 1)) + 128'(ci));
			nzx = sat_coord(((zx2 - zy2) >>> CFB) + 128'(cr));
			zx = nzx;
			zy = nzy;
			wx = 128'(zx);
			wy = 128'(zy);
			zx2 = wx * wx;
			zy2 = wy * wy;
			n++;
			ax = zx[63] ? -zx : zx;
			ay = zy[63] ? -zy : zy;
			half = (ax >> 1) + (ay >> 1) + (ax & ay & 64'd1);
			tol = (half >> 49) + 64'd1;
			dx = (zx < sx) ? sx - zx : zx - sx;
			dy = (zy < sy) ? sy - zy : zy - sy;
			if (dx < tol && dy < tol) begin
				return r;
			end
			if (n == save_at) begin
				sx = zx;
				sy = zy;
				save_at = save_at * 2;
			end
		end
		mag = (zx2 + zy2) >>> MAG_SHIFT;
		r.iters = n[IW-1:0];
		r.mag = (mag[127:32] != '0) ? 32'hFFFF_FFFF : mag[31:0];
		return r;
	endfunction

	task automatic report_mismatch(input string what, input longint got,
		input longint want);
		$display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
		fail_count++;
	endtask

	assign pending_count = expected_escapes.size();

	always @(posedge clk or negedge arst_n) begin
		escape_t e;
		if (!arst_n) begin
			budget <= iter_t'(1000);
			fail_count = 0;
			checked_count = 0;
			interior_count = 0;
			expected_escapes.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				budget <= cfg_data;
			end
			if (in_valid && !in_stall) begin
				e = escape_result(point_real, point_imag, budget);
				if (e.mag == 0 && e.iters == budget) begin
					interior_count++;
				end
				expected_escapes.push_back(e);
			end
			if (out_valid && !out_stall) begin
				if (expected_escapes.size() == 0) begin
					report_mismatch("unexpected result item", iterations, 0);
				end else begin
					e = expected_escapes.pop_front();
					checked_count++;
					if (iterations !== e.iters) begin
						report_mismatch("iterations", iterations, e.iters);
					end
					if (final_magnitude_sq !== e.mag) begin
						report_mismatch("final_magnitude_sq", final_magnitude_sq, e.mag);
					end
				end
			end
		end
	end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Mandelbrot escape iteration testbench
// Drives directed and random points through the block under several iteration
// budgets, with random gaps and stalls and one long result hold-off, while
// the checker predicts and compares every result item.
// ----------------------------------------------------------------------------
module tb_top;
	import mbei_pkg::*;

	localparam logic signed [63:0] ONE = 64'sd1 <<< CFB;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	iter_t       cfg_data;
	logic        in_valid;
	logic        in_stall;
	coord_t      point_real;
	coord_t      point_imag;
	logic        out_valid;
	logic        out_stall;
	iter_t       iterations;
	logic [31:0] final_magnitude_sq;
	int          fail_count;
	int          pending_count;
	int          checked_count;
	int          interior_count;
	int          points_sent;
	logic        burst_mode;
	logic        hold_request;

	mandelbrot_escape_iteration dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.point_real(point_real), .point_imag(point_imag),
		.out_valid(out_valid), .out_stall(out_stall),
		.iterations(iterations), .final_magnitude_sq(final_magnitude_sq)
	);

	mbei_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.point_real(point_real), .point_imag(point_imag),
		.out_valid(out_valid), .out_stall(out_stall),
		.iterations(iterations), .final_magnitude_sq(final_magnitude_sq),
		.fail_count(fail_count), .pending_count(pending_count),
		.checked_count(checked_count), .interior_count(interior_count)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	initial begin
		#40_000_000;
		$display("tb_top: FAIL");
		$finish;
	end

	task automatic send_point(input coord_t re, input coord_t im);
		int gap;
		gap = burst_mode ? 0 : $urandom_range(0, 16);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		point_real <= re;
		point_imag <= im;
		do @(posedge clk); while (in_stall);
		points_sent++;
	endtask

	task automatic set_budget(input iter_t value);
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_count != 0) @(posedge clk);
		repeat (64) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	function automatic coord_t random_coord();
		logic signed [63:0] v;
		int pick;
		v = {$urandom, $urandom};
		pick = $urandom_range(0, 9);
		if (pick < 2) begin
			return v;
		end
		if (pick < 8) begin
			return v >>> 2;
		end
		return (v >>> 4) - (ONE >>> 2);
	endfunction

	always @(posedge clk) begin
		int wait_cycles;
		if (arst_n) begin
			if (hold_request) begin
				out_stall <= 1'b1;
				repeat (3000) @(posedge clk);
				hold_request = 1'b0;
			end
			wait_cycles = burst_mode ? 0 : $urandom_range(0, 16);
			if (wait_cycles > 0) begin
				out_stall <= 1'b1;
				repeat (wait_cycles) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
		end
	end

	initial begin
		iter_t budgets[5];
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		in_valid = 1'b0;
		point_real = '0;
		point_imag = '0;
		out_stall = 1'b0;
		points_sent = 0;
		burst_mode = 1'b0;
		hold_request = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset budget: interior, cusp, bulb, escaping and periodic points.
		send_point(0, 0);
		send_point(ONE >>> 2, 0);
		send_point(-ONE, 0);
		send_point(-(ONE <<< 1), 0);
		send_point(ONE, 0);
		send_point(-ONE - (ONE >>> 2) - (ONE >>> 20), 0);
		send_point((ONE >>> 2) + (ONE >>> 6), 0);
		send_point(0, ONE);
		send_point(-(ONE >>> 1) - (ONE >>> 2), ONE >>> 3);
		send_point(64'sh7FFF_FFFF_FFFF_FFFF, 64'sh7FFF_FFFF_FFFF_FFFF);
		send_point(64'sh8000_0000_0000_0000, 64'sh8000_0000_0000_0000);
		send_point(64'sh8000_0000_0000_0000, 64'sh7FFF_FFFF_FFFF_FFFF);
		send_point(0, 64'sh8000_0000_0000_0000);
		send_point(-1, 1);

		set_budget(iter_t'(16777215));
		send_point(0, 0);
		send_point(-ONE, 0);
		send_point(ONE <<< 1, ONE);
		send_point(64'sh7FFF_FFFF_FFFF_FFFF, 0);

		set_budget(iter_t'(1));
		send_point(0, 0);
		send_point(ONE >>> 1, 0);
		send_point(-(ONE <<< 1), 0);
		send_point(ONE >>> 1, ONE);

		// Long result hold-off while points keep coming in.
		hold_request = 1'b1;
		for (int i = 0; i < 24; i++) begin
			send_point(random_coord(), random_coord());
		end

		budgets = '{iter_t'(1), iter_t'(8), iter_t'(17), iter_t'(40), iter_t'(64)};
		for (int phase = 0; phase < 12; phase++) begin
			set_budget(budgets[$urandom_range(0, 4)] + iter_t'($urandom_range(0, 3)));
			for (int i = 0; i < 48; i++) begin
				if (i % 16 == 0) begin
					burst_mode <= ($urandom_range(0, 3) == 0);
				end
				send_point(random_coord(), random_coord());
			end
			burst_mode <= 1'b0;
		end

		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_count != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		$display("Sent %0d points under budgets from 1 to 16777215; %0d results checked.",
			points_sent, checked_count);
		$display("%0d points were predicted interior or periodic.", interior_count);
		if (fail_count == 0) begin
			$display("tb_top: PASS");
		end else begin
			$display("tb_top: FAIL");
		end
		$finish;
	end

endmodule
